// ===== rtl/assert_macros.svh =====
// Assertion helpers. Each checks on the rising edge of the given clock and is
// disabled while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/sti_pkg.sv =====
package sti_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_READ_OK    = 2'd2,
    ST_READ_RANGE = 2'd3
  } status_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [5:0]  index;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  position;
    logic [31:0] read_key;
    logic [6:0]  count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CMP_FIRST,
    S_CMP_LAST,
    S_BIS_ADDR,
    S_BIS_CMP,
    S_SH_RD,
    S_SH_WR,
    S_WRITE,
    S_RESULT
  } state_t;

endpackage

// ===== rtl/sti_ram.sv =====
module sti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_table_insert.sv =====
// Sorted key table. Keys are kept in ascending order in a single-port-write,
// registered-read RAM, compared signed or unsigned as cfg_data selects. One
// item is in flight at a time and req_stall is high until its result has
// been taken. A read within the entry count goes through S_READ to S_RESULT;
// an insert into a full table or a read past the entry count goes straight
// to S_RESULT, and an insert into an empty table straight to S_WRITE. Any
// other insert compares the new key with the first entry, then with the last,
// and if it falls between them a bisection of at most log2 of the table size
// probes finds its slot, stopping early when a probe hits an equal key. The
// entries from that slot upward each move up one place, so an insert at the
// front moves every entry; every probe and every moved entry costs one RAM
// read and one use of the shared comparator or write port.
`include "assert_macros.svh"

module sorted_table_insert (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sti_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sti_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  import sti_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [KEY_WIDTH-1:0] key_buf, key_buf_next;
  logic [IDX_W-1:0]     lo, lo_next;
  logic [IDX_W-1:0]     hi, hi_next;
  logic [IDX_W-1:0]     mid, mid_next;
  logic [IDX_W-1:0]     ptr, ptr_next;
  logic [IDX_W-1:0]     slot, slot_next;
  logic                 key_signed;
  rsp_t                 rsp_next;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 k_lt;
  logic                 k_eq;
  logic [IDX_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid_calc;

  logic                 is_read;
  logic                 read_ok;
  logic                 tab_full;
  logic                 tab_empty;
  logic                 first_hit;
  logic                 last_hit;
  logic                 bis_go;
  logic                 shift_more;

  sti_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared comparator: new key against the entry just read. Flipping the
  // sign bit turns a two's complement compare into an unsigned one.
  assign sign_flip = KEY_WIDTH'(key_signed) << (KEY_WIDTH - 1);
  assign cmp_a     = key_buf ^ sign_flip;
  assign cmp_b     = ram_rdata ^ sign_flip;
  assign k_lt      = cmp_a < cmp_b;
  assign k_eq      = cmp_a == cmp_b;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[IDX_W:1];

  assign is_read    = req.func == FUNC_READ;
  assign read_ok    = (32'(req.index) < 32'(count)) && (32'(req.index) < 32'(DEPTH));
  assign tab_full   = count == CNT_W'(DEPTH);
  assign tab_empty  = count == '0;
  assign first_hit  = k_lt || k_eq;
  assign last_hit   = !k_lt;
  assign bis_go     = (lo < hi) && (mid_calc != lo);
  assign shift_more = ptr > slot;

  assign req_stall = state != S_IDLE;
  assign rsp_valid = state == S_RESULT;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (is_read) begin
            state_next = read_ok ? S_READ : S_RESULT;
          end else if (tab_full) begin
            state_next = S_RESULT;
          end else if (tab_empty) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_CMP_FIRST;
          end
        end
      end
      S_READ:      state_next = S_RESULT;
      S_CMP_FIRST: state_next = first_hit ? S_SH_RD : S_CMP_LAST;
      S_CMP_LAST:  state_next = last_hit ? S_WRITE : S_BIS_ADDR;
      S_BIS_ADDR:  state_next = bis_go ? S_BIS_CMP : S_SH_RD;
      S_BIS_CMP:   state_next = k_eq ? S_SH_RD : S_BIS_ADDR;
      S_SH_RD:     state_next = shift_more ? S_SH_WR : S_WRITE;
      S_SH_WR:     state_next = S_SH_RD;
      S_WRITE:     state_next = S_RESULT;
      S_RESULT: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next   = count;
    key_buf_next = key_buf;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    ptr_next     = ptr;
    slot_next    = slot;
    rsp_next     = rsp;
    ram_we       = 1'b0;
    ram_waddr    = ptr;
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    unique case (state)
      S_IDLE: begin
        key_buf_next = KEY_WIDTH'(req.key);
        ram_raddr    = IDX_W'(req.index);
        slot_next    = '0;
        rsp_next     = '{status: ST_READ_RANGE, position: '0, read_key: '0,
                         count: 7'(count)};
        if (!is_read) begin
          ram_raddr = '0;
          if (tab_full) begin
            rsp_next.status = ST_FULL;
          end
        end
      end
      S_READ: begin
        rsp_next = '{status: ST_READ_OK, position: '0, read_key: 32'(ram_rdata),
                     count: 7'(count)};
      end
      S_CMP_FIRST: begin
        ptr_next  = IDX_W'(count);
        ram_raddr = IDX_W'(count - 1'b1);
      end
      S_CMP_LAST: begin
        slot_next = IDX_W'(count);
        lo_next   = '0;
        hi_next   = IDX_W'(count - 1'b1);
      end
      S_BIS_ADDR: begin
        if (bis_go) begin
          mid_next  = mid_calc;
          ram_raddr = mid_calc;
        end else begin
          slot_next = IDX_W'(lo + 1'b1);
          ptr_next  = IDX_W'(count);
        end
      end
      S_BIS_CMP: begin
        if (k_eq) begin
          slot_next = mid;
          ptr_next  = IDX_W'(count);
        end else if (k_lt) begin
          hi_next = mid;
        end else begin
          lo_next = mid;
        end
      end
      S_SH_RD: begin
        ram_raddr = IDX_W'(ptr - 1'b1);
      end
      S_SH_WR: begin
        // The entry below ptr was read last cycle and moves up one place.
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = ram_rdata;
        ptr_next  = IDX_W'(ptr - 1'b1);
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = slot;
        ram_wdata  = key_buf;
        count_next = CNT_W'(count + 1'b1);
        rsp_next   = '{status: ST_INSERTED, position: 7'(slot), read_key: '0,
                       count: 7'(count + 1'b1)};
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      key_signed <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        key_signed <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_buf <= key_buf_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    ptr     <= ptr_next;
    slot    <= slot_next;
    rsp     <= rsp_next;
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_pos_in_table, clk, rst, rsp_valid && rsp.status == ST_INSERTED, rsp.position < rsp.count)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, state != S_IDLE)
  `ASSERT_IMPLY(a_shift_bound, clk, rst, state == S_SH_WR, ptr > slot)

endmodule
